// ===== src/euclidean_prim_mst_3d_macros.svh =====
// ----------------------------------------------------------------------------
// euclidean_prim_mst_3d assertion macros
// concurrent assertion wrappers used by the checker file epmst_chk
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_PRIM_MST_3D_MACROS_SVH
`define EUCLIDEAN_PRIM_MST_3D_MACROS_SVH

// property checked on every rising edge out of reset
`define EPMST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define EPMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/epmst_pkg.sv =====
// ----------------------------------------------------------------------------
// epmst_pkg
// shared widths, types and state codes of the 3d prim spanning tree block
// ----------------------------------------------------------------------------
package epmst_pkg;

    // default point capacity
    localparam int MAX_POINTS_DEF = 64;

    // coordinate, squared distance and id widths
    localparam int COORD_W = 20;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int ID_W    = 7;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [ID_W-1:0]    id_t;

    // no squared distance reaches this value
    localparam dist_t DIST_INF = '1;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // what travels with each candidate down the distance pipeline
    typedef struct packed {
        logic   skip;
        dist_t  best;
        point_t pt;
    } tag_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROOT,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

// ===== src/epmst_ram.sv =====
// ----------------------------------------------------------------------------
// epmst_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module epmst_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [$clog2(D)-1:0] wr_addr,
    input  logic [W-1:0]         wr_data,
    input  logic [$clog2(D)-1:0] rd_addr,
    output logic [W-1:0]         rd_data
);

    logic [W-1:0] mem [D];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/epmst_dist.sv =====
// ----------------------------------------------------------------------------
// epmst_dist
// three stage squared distance pipeline: abs difference, square, sum
// ----------------------------------------------------------------------------
module epmst_dist #(
    parameter int MAX_POINTS = epmst_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  epmst_pkg::point_t             k_pt,
    input  logic                          valid_in,
    input  epmst_pkg::tag_t               tag_in,
    input  logic [$clog2(MAX_POINTS)-1:0] idx_in,
    input  logic [$clog2(MAX_POINTS)-1:0] par_in,
    output logic                          valid_out,
    output epmst_pkg::tag_t               tag_out,
    output logic [$clog2(MAX_POINTS)-1:0] idx_out,
    output logic [$clog2(MAX_POINTS)-1:0] par_out,
    output epmst_pkg::dist_t              dist_out,
    output logic                          busy
);

    localparam int IW = $clog2(MAX_POINTS);

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    epmst_pkg::tag_t       s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [IW-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [IW-1:0]         s1_par_reg, s2_par_reg, s3_par_reg;
    epmst_pkg::coord_t     dx_next, dy_next, dz_next;
    epmst_pkg::coord_t     dx_reg, dy_reg, dz_reg;
    epmst_pkg::sq_t        sqx_next, sqy_next, sqz_next;
    epmst_pkg::sq_t        sqx_reg, sqy_reg, sqz_reg;
    epmst_pkg::dist_t      dist_next, dist_reg;

    // absolute coordinate differences against the newest tree point
    always_comb
    begin
        dx_next = (tag_in.pt.x > k_pt.x) ? tag_in.pt.x - k_pt.x : k_pt.x - tag_in.pt.x;
        dy_next = (tag_in.pt.y > k_pt.y) ? tag_in.pt.y - k_pt.y : k_pt.y - tag_in.pt.y;
        dz_next = (tag_in.pt.z > k_pt.z) ? tag_in.pt.z - k_pt.z : k_pt.z - tag_in.pt.z;
    end

    // squares and their sum
    always_comb
    begin
        sqx_next  = epmst_pkg::SQ_W'(dx_reg) * epmst_pkg::SQ_W'(dx_reg);
        sqy_next  = epmst_pkg::SQ_W'(dy_reg) * epmst_pkg::SQ_W'(dy_reg);
        sqz_next  = epmst_pkg::SQ_W'(dz_reg) * epmst_pkg::SQ_W'(dz_reg);
        dist_next = epmst_pkg::DIST_W'(sqx_reg) + epmst_pkg::DIST_W'(sqy_reg)
                  + epmst_pkg::DIST_W'(sqz_reg);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= tag_in;
        s1_idx_reg <= idx_in;
        s1_par_reg <= par_in;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        s2_tag_reg <= s1_tag_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_par_reg <= s1_par_reg;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        sqz_reg    <= sqz_next;
        s3_tag_reg <= s2_tag_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_par_reg <= s2_par_reg;
        dist_reg   <= dist_next;
    end

    assign valid_out = s3_valid_reg;
    assign tag_out   = s3_tag_reg;
    assign idx_out   = s3_idx_reg;
    assign par_out   = s3_par_reg;
    assign dist_out  = dist_reg;
    assign busy      = s1_valid_reg | s2_valid_reg | s3_valid_reg;

endmodule

// ===== src/epmst_update.sv =====
// ----------------------------------------------------------------------------
// epmst_update
// relaxes each point's best tree distance and tracks the sweep minimum
// ----------------------------------------------------------------------------
module epmst_update #(
    parameter int MAX_POINTS = epmst_pkg::MAX_POINTS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [$clog2(MAX_POINTS)-1:0]              k_idx,
    input  logic                                       valid_in,
    input  epmst_pkg::tag_t                            tag_in,
    input  logic [$clog2(MAX_POINTS)-1:0]              idx_in,
    input  logic [$clog2(MAX_POINTS)-1:0]              par_in,
    input  epmst_pkg::dist_t                           dist_in,
    output logic                                       wr_en,
    output logic [$clog2(MAX_POINTS)-1:0]              wr_addr,
    output logic [epmst_pkg::DIST_W+$clog2(MAX_POINTS)-1:0] wr_data,
    output logic [$clog2(MAX_POINTS)-1:0]              min_idx,
    output logic [$clog2(MAX_POINTS)-1:0]              min_par,
    output epmst_pkg::point_t                          min_pt,
    output logic                                       busy
);

    localparam int IW = $clog2(MAX_POINTS);

    logic              take;
    epmst_pkg::dist_t  best_next;
    logic [IW-1:0]     par_next;
    logic              s4_valid_reg;
    logic              s4_skip_reg;
    epmst_pkg::dist_t  s4_best_reg;
    logic [IW-1:0]     s4_par_reg;
    logic [IW-1:0]     s4_idx_reg;
    epmst_pkg::point_t s4_pt_reg;
    logic              better;
    logic              found_reg;
    epmst_pkg::dist_t  min_dist_reg;
    logic [IW-1:0]     min_idx_reg;
    logic [IW-1:0]     min_par_reg;
    epmst_pkg::point_t min_pt_reg;

    // relax: closer, or equally close to a lower tree index
    always_comb
    begin
        take = (dist_in < tag_in.best) || ((dist_in == tag_in.best) && (k_idx < par_in));
        best_next = take ? dist_in : tag_in.best;
        par_next  = take ? k_idx : par_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_skip_reg <= tag_in.skip;
        s4_best_reg <= best_next;
        s4_par_reg  <= par_next;
        s4_idx_reg  <= idx_in;
        s4_pt_reg   <= tag_in.pt;
    end

    // write back the relaxed entry of a point still outside the tree
    assign wr_en   = s4_valid_reg && !s4_skip_reg;
    assign wr_addr = s4_idx_reg;
    assign wr_data = {s4_best_reg, s4_par_reg};

    // running minimum over (distance, parent); lower index wins on a full tie
    assign better = s4_valid_reg && !s4_skip_reg
                 && (!found_reg || (s4_best_reg < min_dist_reg)
                     || ((s4_best_reg == min_dist_reg) && (s4_par_reg < min_par_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
        end
        else if (better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            min_dist_reg <= s4_best_reg;
            min_idx_reg  <= s4_idx_reg;
            min_par_reg  <= s4_par_reg;
            min_pt_reg   <= s4_pt_reg;
        end
    end

    assign min_idx = min_idx_reg;
    assign min_par = min_par_reg;
    assign min_pt  = min_pt_reg;
    assign busy    = s4_valid_reg;

endmodule

// ===== src/euclidean_prim_mst_3d.sv =====
// ----------------------------------------------------------------------------
// euclidean_prim_mst_3d
// prim minimum spanning tree over a set of 3d points, squared distance metric
// ----------------------------------------------------------------------------
// Input channel: one point word per handshake (point_x/y/z, final_point).
// Points are stored in order; final_point, or filling the last free entry,
// closes the set and starts the build from point 0.
// Output channel: one tree word per handshake, root first with parent 0,
// then each point in join order with its 1-based parent; final_edge marks
// the last word of the set.
// Build: once the closing point is taken, the root word is registered as soon
// as the output register is free. Each further word takes one sweep of the
// point and best-distance memories per join through a single distance
// pipeline that takes one point per cycle. The input is stalled from the
// closing point until the last word sits in the output register.
// Reset: the set is emptied and nothing is pending; memory contents are
// not cleared since every entry is written before its contents are used.
// A stalled output holds its word; the build waits until the output
// register frees before handing over the next word.
// ----------------------------------------------------------------------------
module euclidean_prim_mst_3d #(
    parameter int MAX_POINTS = epmst_pkg::MAX_POINTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  epmst_pkg::coord_t point_x,
    input  epmst_pkg::coord_t point_y,
    input  epmst_pkg::coord_t point_z,
    input  logic              final_point,
    output logic              out_valid,
    input  logic              out_stall,
    output epmst_pkg::id_t    node_id,
    output epmst_pkg::id_t    parent_id,
    output epmst_pkg::coord_t node_x,
    output epmst_pkg::coord_t node_y,
    output epmst_pkg::coord_t node_z,
    output logic              final_edge
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int BW = epmst_pkg::DIST_W + IW;

    epmst_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]       loaded_reg, loaded_next;
    logic [CW-1:0]       joined_reg, joined_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                first_reg, first_next;
    logic [MAX_POINTS-1:0] in_tree_reg, in_tree_next;
    logic [IW-1:0]       k_idx_reg, k_idx_next;
    epmst_pkg::point_t   k_pt_reg, k_pt_next;
    logic                p0_valid_reg, p0_valid_next;
    logic [IW-1:0]       p0_idx_reg, p0_idx_next;
    logic                p0_skip_reg, p0_skip_next;
    logic                out_valid_reg, out_valid_next;
    epmst_pkg::id_t      node_id_reg, node_id_next;
    epmst_pkg::id_t      parent_id_reg, parent_id_next;
    epmst_pkg::point_t   node_pt_reg, node_pt_next;
    logic                final_edge_reg, final_edge_next;

    logic                out_free;
    logic                last_word;
    logic                start_sweep;
    logic                pt_we;
    epmst_pkg::point_t   in_pt;
    epmst_pkg::point_t   pt_rdata;
    logic [BW-1:0]       best_rdata;
    epmst_pkg::tag_t     tag0;
    logic                d_valid;
    epmst_pkg::tag_t     d_tag;
    logic [IW-1:0]       d_idx, d_par;
    epmst_pkg::dist_t    d_dist;
    logic                dist_busy;
    logic                best_we;
    logic [IW-1:0]       best_waddr;
    logic [BW-1:0]       best_wdata;
    logic [IW-1:0]       min_idx, min_par;
    epmst_pkg::point_t   min_pt;
    logic                upd_busy;

    assign in_pt    = '{x: point_x, y: point_y, z: point_z};
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != epmst_pkg::ST_LOAD);

    // point store
    epmst_ram #(
        .W ($bits(epmst_pkg::point_t)),
        .D (MAX_POINTS)
    ) u_pt_ram (
        .clk     (clk),
        .wr_en   (pt_we),
        .wr_addr (loaded_reg[IW-1:0]),
        .wr_data (in_pt),
        .rd_addr (j_reg[IW-1:0]),
        .rd_data (pt_rdata)
    );

    // best distance to the tree and its parent, per point
    epmst_ram #(
        .W (BW),
        .D (MAX_POINTS)
    ) u_best_ram (
        .clk     (clk),
        .wr_en   (best_we),
        .wr_addr (best_waddr),
        .wr_data (best_wdata),
        .rd_addr (j_reg[IW-1:0]),
        .rd_data (best_rdata)
    );

    // candidate entering the distance pipeline, first sweep starts from infinity
    always_comb
    begin
        tag0.skip = p0_skip_reg;
        tag0.best = first_reg ? epmst_pkg::DIST_INF : best_rdata[BW-1:IW];
        tag0.pt   = pt_rdata;
    end

    epmst_dist #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .k_pt      (k_pt_reg),
        .valid_in  (p0_valid_reg),
        .tag_in    (tag0),
        .idx_in    (p0_idx_reg),
        .par_in    (best_rdata[IW-1:0]),
        .valid_out (d_valid),
        .tag_out   (d_tag),
        .idx_out   (d_idx),
        .par_out   (d_par),
        .dist_out  (d_dist),
        .busy      (dist_busy)
    );

    epmst_update #(
        .MAX_POINTS (MAX_POINTS)
    ) u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_sweep),
        .k_idx    (k_idx_reg),
        .valid_in (d_valid),
        .tag_in   (d_tag),
        .idx_in   (d_idx),
        .par_in   (d_par),
        .dist_in  (d_dist),
        .wr_en    (best_we),
        .wr_addr  (best_waddr),
        .wr_data  (best_wdata),
        .min_idx  (min_idx),
        .min_par  (min_par),
        .min_pt   (min_pt),
        .busy     (upd_busy)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epmst_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        joined_next     = joined_reg;
        j_next          = j_reg;
        first_next      = first_reg;
        in_tree_next    = in_tree_reg;
        k_idx_next      = k_idx_reg;
        k_pt_next       = k_pt_reg;
        p0_valid_next   = 1'b0;
        p0_idx_next     = p0_idx_reg;
        p0_skip_next    = p0_skip_reg;
        out_valid_next  = out_valid_reg && out_stall;
        node_id_next    = node_id_reg;
        parent_id_next  = parent_id_reg;
        node_pt_next    = node_pt_reg;
        final_edge_next = final_edge_reg;
        start_sweep     = 1'b0;
        pt_we           = 1'b0;
        last_word       = 1'b0;

        case (state_reg)
            epmst_pkg::ST_LOAD:
            begin
                if (in_valid)
                begin
                    pt_we       = 1'b1;
                    loaded_next = loaded_reg + CW'(1);
                    if (loaded_reg == '0)
                    begin
                        k_pt_next = in_pt;
                    end
                    if (final_point || (loaded_next == CW'(MAX_POINTS)))
                    begin
                        state_next = epmst_pkg::ST_ROOT;
                    end
                end
            end

            // root word, then, unless it is the only point, the first sweep from point 0
            epmst_pkg::ST_ROOT:
            begin
                if (out_free)
                begin
                    last_word       = (loaded_reg == CW'(1));
                    out_valid_next  = 1'b1;
                    node_id_next    = epmst_pkg::id_t'(1);
                    parent_id_next  = '0;
                    node_pt_next    = k_pt_reg;
                    final_edge_next = last_word;
                    k_idx_next      = '0;
                    if (last_word)
                    begin
                        loaded_next  = '0;
                        in_tree_next = '0;
                        state_next   = epmst_pkg::ST_LOAD;
                    end
                    else
                    begin
                        in_tree_next = MAX_POINTS'(1);
                        joined_next  = CW'(1);
                        j_next       = '0;
                        first_next   = 1'b1;
                        state_next   = epmst_pkg::ST_SWEEP;
                    end
                end
            end

            // one point per cycle into the distance pipeline
            epmst_pkg::ST_SWEEP:
            begin
                start_sweep   = (j_reg == '0);
                p0_valid_next = 1'b1;
                p0_idx_next   = j_reg[IW-1:0];
                p0_skip_next  = in_tree_reg[j_reg[IW-1:0]];
                if (j_reg == loaded_reg - CW'(1))
                begin
                    state_next = epmst_pkg::ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end

            // wait for the last candidate to settle the minimum
            epmst_pkg::ST_DRAIN:
            begin
                if (!p0_valid_reg && !dist_busy && !upd_busy)
                begin
                    state_next = epmst_pkg::ST_EMIT;
                end
            end

            // hand over the joining point and grow the tree
            epmst_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    last_word       = (joined_reg + CW'(1) == loaded_reg);
                    out_valid_next  = 1'b1;
                    node_id_next    = epmst_pkg::id_t'(min_idx) + epmst_pkg::id_t'(1);
                    parent_id_next  = epmst_pkg::id_t'(min_par) + epmst_pkg::id_t'(1);
                    node_pt_next    = min_pt;
                    final_edge_next = last_word;
                    k_idx_next      = min_idx;
                    k_pt_next       = min_pt;
                    first_next      = 1'b0;
                    joined_next     = joined_reg + CW'(1);
                    if (last_word)
                    begin
                        loaded_next  = '0;
                        in_tree_next = '0;
                        state_next   = epmst_pkg::ST_LOAD;
                    end
                    else
                    begin
                        in_tree_next[min_idx] = 1'b1;
                        j_next       = '0;
                        state_next   = epmst_pkg::ST_SWEEP;
                    end
                end
            end

            default:
            begin
                state_next = epmst_pkg::ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            joined_reg    <= '0;
            j_reg         <= '0;
            first_reg     <= 1'b0;
            in_tree_reg   <= '0;
            p0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            joined_reg    <= joined_next;
            j_reg         <= j_next;
            first_reg     <= first_next;
            in_tree_reg   <= in_tree_next;
            p0_valid_reg  <= p0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_idx_reg      <= k_idx_next;
        k_pt_reg       <= k_pt_next;
        p0_idx_reg     <= p0_idx_next;
        p0_skip_reg    <= p0_skip_next;
        node_id_reg    <= node_id_next;
        parent_id_reg  <= parent_id_next;
        node_pt_reg    <= node_pt_next;
        final_edge_reg <= final_edge_next;
    end

    assign out_valid  = out_valid_reg;
    assign node_id    = node_id_reg;
    assign parent_id  = parent_id_reg;
    assign node_x     = node_pt_reg.x;
    assign node_y     = node_pt_reg.y;
    assign node_z     = node_pt_reg.z;
    assign final_edge = final_edge_reg;

endmodule

// ===== src/epmst_chk.sv =====
// ----------------------------------------------------------------------------
// epmst_chk
// port level checks of the 3d prim spanning tree block, bound to the top
// ----------------------------------------------------------------------------
`include "euclidean_prim_mst_3d_macros.svh"

module epmst_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              final_point,
    input logic              out_valid,
    input logic              out_stall,
    input epmst_pkg::id_t    node_id,
    input epmst_pkg::id_t    parent_id,
    input epmst_pkg::coord_t node_x,
    input epmst_pkg::coord_t node_y,
    input epmst_pkg::coord_t node_z,
    input logic              final_edge
);

    // no word is offered in the cycle after a reset cycle
    `EPMST_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid, "output valid in reset")

    // a stalled word keeps its ids, coordinates and last flag
    `EPMST_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable({node_id, parent_id, node_x, node_y, node_z, final_edge}), "stalled word changed")

    // ids are 1-based and a point never is its own parent
    `EPMST_ASSERT(a_ids, clk, rst_n, out_valid |-> (node_id != 0) && (node_id != parent_id), "bad node or parent id")

    // only the first point can be the root
    `EPMST_ASSERT(a_root, clk, rst_n, out_valid && (parent_id == 0) |-> (node_id == 1), "root is not point one")

    // closing a set with final_point stops the input once that point is taken
    `EPMST_ASSERT(a_close, clk, rst_n, in_valid && !in_stall && final_point |=> in_stall, "input open after last point")

endmodule

bind euclidean_prim_mst_3d epmst_chk u_epmst_chk (.*);
